// ===== src/adc_reading_to_lcd_text_unit_assert.svh =====
// Assertion macros for the display formatter.
// ADC_ASSERT is held off while rst is high; ADC_ASSERT_ALWAYS also checks during reset.
`ifndef ADC_READING_TO_LCD_TEXT_UNIT_ASSERT_SVH
`define ADC_READING_TO_LCD_TEXT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define ADC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("adc_reading_to_lcd_text_unit: check failed");

`define ADC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("adc_reading_to_lcd_text_unit: reset check failed");

`else

`define ADC_ASSERT(label, prop)

`define ADC_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== src/adclcd_pkg.sv =====
package adclcd_pkg;

  // Port width of the converter reading
  localparam int SampleW = 12;
  localparam int SampleBitsDefault = 12;

  localparam int VoltScale = 33;
  localparam int PctScale = 100;

  // Display characters
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot = 8'h2E;
  localparam logic [7:0] CharVolt = 8'h56;
  localparam logic [7:0] CharPct = 8'h25;

  // Reciprocal of ten: (x * 52429) >> 19 is exact for any 16-bit x
  localparam logic [31:0] DivTenMul = 32'd52429;
  localparam int DivTenShift = 19;

  // Everything the byte sequencer needs for one reading
  typedef struct packed {
    logic [7:0] addr;
    logic [3:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [3:0] volt_int;
    logic [3:0] volt_frac;
    logic       pct_three;
    logic [3:0] pct_tens;
    logic [3:0] pct_ones;
  } text_t;

  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * DivTenMul;
    return p[31:DivTenShift];
  endfunction

  function automatic logic [3:0] rem10(input logic [15:0] x, input logic [12:0] q);
    logic [15:0] t;
    t = x - (16'(q) << 3) - (16'(q) << 1);
    return t[3:0];
  endfunction

endpackage

// ===== src/adc_reading_to_lcd_text_unit.sv =====
// The first display byte (set-address command) is valid once the reading has passed
// stages 1 to 4 and the sequencer load; the 14 bytes (15 for a full-scale "100%") then
// follow one a cycle while text_stall is low; the single byte output port sets the reading rate.
// The 4-stage front pipeline takes a reading a cycle while reading_stall is low.
// Reset (rst, synchronous): all pipeline words and the sequencer are dropped, no byte is shown.
`include "adc_reading_to_lcd_text_unit_assert.svh"

module adc_reading_to_lcd_text_unit #(
  parameter int SAMPLE_BITS = adclcd_pkg::SampleBitsDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           reading_valid,
  output logic                           reading_stall,
  input  logic [adclcd_pkg::SampleW-1:0] sample,
  input  logic [7:0]                     line_address,
  output logic                           text_valid,
  input  logic                           text_stall,
  output logic                           is_data,
  output logic [7:0]                     byte_out,
  output logic                           last
);
  import adclcd_pkg::*;

  localparam int ExtW = (SAMPLE_BITS > SampleW) ? SAMPLE_BITS : SampleW;
  localparam int VProdW = SAMPLE_BITS + 6;
  localparam int PProdW = SAMPLE_BITS + 7;
  localparam logic [SAMPLE_BITS:0] FullScale = (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) - 1);

  typedef enum logic [3:0] {
    SlotAddr, SlotThou, SlotHund, SlotTens, SlotOnes, SlotGap1,
    SlotVoltInt, SlotDot, SlotVoltFrac, SlotVoltUnit, SlotGap2,
    SlotPctHund, SlotPctTens, SlotPctOnes, SlotPctSign
  } slot_t;

  // stage registers
  logic                   v1, v2, v3, v4;
  logic [SAMPLE_BITS-1:0] s1;
  logic [7:0]             a1, a2, a3;
  logic [9:0]             q1_2;
  logic [3:0]             d0_2, d0_3, d1_3;
  logic [VProdW-1:0]      xv2;
  logic [PProdW-1:0]      xp2;
  logic [6:0]             q2_3;
  logic [5:0]             volts3;
  logic [6:0]             pct3;
  text_t                  txt4;

  // sequencer registers
  logic  busy;
  slot_t idx;
  text_t cur;

  logic r1, r2, r3, r4, load;
  logic [ExtW-1:0] s_ext;

  // stage 3 quotient by full scale: q0 = x >> B, remainder (x mod 2^B) + q0, one correction
  logic [5:0]             qv0;
  logic [6:0]             qp0;
  logic [SAMPLE_BITS:0]   rv, rp;
  logic [5:0]             volts_next;
  logic [6:0]             pct_next;

  // stage 4 digit split
  logic       three_next;
  logic [6:0] prest;
  logic [12:0] q3, qvt, qpt, q2_full;

  // handshake chain: a stage takes a new word when empty or when its word moves on
  assign load = v4 && (!busy || (!text_stall && idx == SlotPctSign));
  assign r4 = !v4 || load;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign reading_stall = !r1;

  assign s_ext = ExtW'(sample);

  always_comb begin
    qv0 = xv2[VProdW-1:SAMPLE_BITS];
    qp0 = xp2[PProdW-1:SAMPLE_BITS];
    rv = {1'b0, xv2[SAMPLE_BITS-1:0]} + (SAMPLE_BITS + 1)'(qv0);
    rp = {1'b0, xp2[SAMPLE_BITS-1:0]} + (SAMPLE_BITS + 1)'(qp0);
    volts_next = (rv >= FullScale) ? 6'(qv0 + 6'd1) : qv0;
    pct_next = (rp >= FullScale) ? 7'(qp0 + 7'd1) : qp0;
    q2_full = div10(16'(q1_2));
  end

  always_comb begin
    three_next = pct3 > 7'd99;
    prest = three_next ? 7'(pct3 - 7'd100) : pct3;
    q3 = div10(16'(q2_3));
    qvt = div10(16'(volts3));
    qpt = div10(16'(prest));
  end

  // stage 1: capture the masked reading
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= reading_valid;
    end
    if (r1) begin
      s1 <= s_ext[SAMPLE_BITS-1:0];
      a1 <= line_address;
    end
  end

  // stage 2: scale products and first decimal digit
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2) begin
      a2 <= a1;
      q1_2 <= 10'(div10(16'(s1)));
      d0_2 <= rem10(16'(s1), div10(16'(s1)));
      xv2 <= VProdW'(s1) * VProdW'(VoltScale);
      xp2 <= PProdW'(s1) * PProdW'(PctScale);
    end
  end

  // stage 3: divide by full scale, second digit
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3) begin
      a3 <= a2;
      d0_3 <= d0_2;
      d1_3 <= rem10(16'(q1_2), q2_full);
      q2_3 <= 7'(q2_full);
      volts3 <= volts_next;
      pct3 <= pct_next;
    end
  end

  // stage 4: remaining digits
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
    if (r4) begin
      txt4.addr <= a3;
      txt4.ones <= d0_3;
      txt4.tens <= d1_3;
      txt4.hund <= rem10(16'(q2_3), q3);
      txt4.thou <= 4'(q3);
      txt4.volt_int <= 4'(qvt);
      txt4.volt_frac <= rem10(16'(volts3), qvt);
      txt4.pct_three <= three_next;
      txt4.pct_tens <= 4'(qpt);
      txt4.pct_ones <= rem10(16'(prest), qpt);
    end
  end

  // byte sequencer: one display word a cycle unless text_stall, hundreds of percent only at full scale
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= SlotAddr;
    end else if (load) begin
      busy <= 1'b1;
      idx <= SlotAddr;
    end else if (busy && !text_stall) begin
      if (idx == SlotPctSign) begin
        busy <= 1'b0;
      end else if (idx == SlotGap2 && !cur.pct_three) begin
        idx <= SlotPctTens;
      end else begin
        idx <= slot_t'(4'(idx + 4'd1));
      end
    end
    if (load) begin
      cur <= txt4;
    end
  end

  // output word select
  always_comb begin
    is_data = 1'b1;
    last = 1'b0;
    case (idx)
      SlotAddr: begin
        is_data = 1'b0;
        byte_out = cur.addr;
      end
      SlotThou:     byte_out = AsciiZero + 8'(cur.thou);
      SlotHund:     byte_out = AsciiZero + 8'(cur.hund);
      SlotTens:     byte_out = AsciiZero + 8'(cur.tens);
      SlotOnes:     byte_out = AsciiZero + 8'(cur.ones);
      SlotGap1:     byte_out = CharSpace;
      SlotVoltInt:  byte_out = AsciiZero + 8'(cur.volt_int);
      SlotDot:      byte_out = CharDot;
      SlotVoltFrac: byte_out = AsciiZero + 8'(cur.volt_frac);
      SlotVoltUnit: byte_out = CharVolt;
      SlotGap2:     byte_out = CharSpace;
      SlotPctHund:  byte_out = AsciiZero + 8'(cur.pct_three);
      SlotPctTens:  byte_out = AsciiZero + 8'(cur.pct_tens);
      SlotPctOnes:  byte_out = AsciiZero + 8'(cur.pct_ones);
      SlotPctSign: begin
        byte_out = CharPct;
        last = 1'b1;
      end
      default:      byte_out = CharSpace;
    endcase
  end

  assign text_valid = busy;

  // checks
  `ADC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !text_valid)
  `ADC_ASSERT(a_cmd_after_last, text_valid && !text_stall && last |=> !text_valid || !is_data)
  `ADC_ASSERT(a_hund_full_only, busy && idx == SlotPctHund |-> cur.pct_three)
  `ADC_ASSERT(a_scaled_range, v3 |-> volts3 <= 6'd33 && pct3 <= 7'd100)
  `ADC_ASSERT(a_s4_holds, v4 && !load |=> v4 && $stable(txt4))

endmodule
